/* rtl/qasf_pkg.sv */
// ----------------------------------------------------------------------------
// qasf_pkg
// Shared types and constants for the quote-aware substring finder.
// ----------------------------------------------------------------------------
package qasf_pkg;

  localparam int POS_W     = 16;  // width of the reported position
  localparam int DEPTH_W   = 16;  // paren depth and subquery level, wrapping
  localparam int WIN_DEPTH = 22;  // lookahead window entries
  localparam int WIN_IDX_W = 5;   // holds 0..WIN_DEPTH
  localparam int SELECT_LEN = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  // "select", exact lower case
  localparam logic [7:0] SELECT_WORD [SELECT_LEN] =
    '{8'h73, 8'h65, 8'h6c, 8'h65, 8'h63, 8'h74};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd3;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_SPACE,
    KIND_BSLASH,
    KIND_QUOTE,
    KIND_OPEN,
    KIND_CLOSE
  } kind_e;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] folded;
    kind_e      kind;
  } char_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

  typedef struct packed {
    logic [4:0]  pattern_length;
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] start_offset;
  } cfg_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

/* rtl/qasf_fifo.sv */
// ----------------------------------------------------------------------------
// qasf_fifo
// Small register FIFO with count-based full and empty flags.
// ----------------------------------------------------------------------------
module qasf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/qasf_front.sv */
// ----------------------------------------------------------------------------
// qasf_front
// Takes text bytes, classifies them and queues them for the scanner.
// ----------------------------------------------------------------------------
module qasf_front
  import qasf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       valid_o,
  output item_t      item_o,
  input  logic       pop_i
);

  item_t            item_in;
  logic             empty;
  logic [$bits(item_t)-1:0] q_data;

  always_comb begin
    item_in.ch.raw    = text_byte_i;
    item_in.ch.folded = fold(text_byte_i);
    item_in.last      = last_byte_i;
    case (text_byte_i)
      CH_SPACE:  item_in.ch.kind = KIND_SPACE;
      CH_BSLASH: item_in.ch.kind = KIND_BSLASH;
      CH_QUOTE:  item_in.ch.kind = KIND_QUOTE;
      CH_OPEN:   item_in.ch.kind = KIND_OPEN;
      CH_CLOSE:  item_in.ch.kind = KIND_CLOSE;
      default:   item_in.ch.kind = KIND_OTHER;
    endcase
  end

  qasf_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (pop_i),
    .data_o (q_data),
    .empty_o(empty)
  );

  assign valid_o = !empty;
  assign item_o  = item_t'(q_data);

endmodule

/* rtl/qasf_back.sv */
// ----------------------------------------------------------------------------
// qasf_back
// Lookahead window and scan state; decides one text position per cycle while no result waits on a full result queue.
// ----------------------------------------------------------------------------
module qasf_back
  import qasf_pkg::*;
#(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_pop_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

  localparam int SUM_W = ((POSITION_BITS > POS_W) ? POSITION_BITS : POS_W) + 1;
  localparam logic [POSITION_BITS-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(CNT_MAX);

  char_t                   win_q [WIN_DEPTH];
  char_t                   win_d [WIN_DEPTH];
  logic [WIN_IDX_W-1:0]    fill_q, fill_d, wr_idx;
  logic                    last_seen_q, last_seen_d;
  logic                    esc_q, esc_d, esc_n;
  logic                    skip_q, skip_d, skip_n;
  logic                    quote_q, quote_d, quote_n;
  logic                    sub_q, sub_d, sub_n;
  logic [DEPTH_W-1:0]      depth_q, depth_d, depth_n;
  logic [DEPTH_W-1:0]      level_q, level_d, level_n;
  logic [POSITION_BITS-1:0] byte_cnt_q, byte_cnt_d;
  logic [POSITION_BITS-1:0] scan_idx_q, scan_idx_d;
  logic                    discard_q, discard_d;

  char_t                   head;
  logic [4:0]              len_eff;
  logic [127:0]            pat_bytes;
  logic                    pat_hit, sel_hit;
  logic                    consume, hit, proceed;
  logic                    not_found, emit, stall, room, append, drop;
  logic [SUM_W-1:0]        pos_sum, pos_sat;

  assign head      = win_q[0];
  assign pat_bytes = {cfg_i.pattern_high, cfg_i.pattern_low};

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = 5'd1;
    end else if (cfg_i.pattern_length > 5'(PATTERN_MAX)) begin
      len_eff = 5'(PATTERN_MAX);
    end else begin
      len_eff = cfg_i.pattern_length;
    end
  end

  // parallel compares against the window head; bytes past the end mismatch
  always_comb begin
    pat_hit = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (5'(j) < len_eff) begin
        if (!(WIN_IDX_W'(j) < fill_q &&
              win_q[j].folded == fold(pat_bytes[8*j +: 8]))) begin
          pat_hit = 1'b0;
        end
      end
    end
    sel_hit = (fill_q >= WIN_IDX_W'(SELECT_LEN));
    for (int k = 0; k < SELECT_LEN; k++) begin
      if (win_q[k].raw != SELECT_WORD[k]) begin
        sel_hit = 1'b0;
      end
    end
  end

  // decision on the head position
  always_comb begin
    consume = 1'b0;
    hit     = 1'b0;
    proceed = 1'b0;
    esc_n   = esc_q;
    skip_n  = skip_q;
    quote_n = quote_q;
    sub_n   = sub_q;
    depth_n = depth_q;
    level_n = level_q;
    if (fill_q != '0 && !discard_q) begin
      if (esc_q) begin
        esc_n   = 1'b0;
        consume = 1'b1;
      end else begin
        proceed = 1'b1;
        if (skip_q) begin
          if (head.kind == KIND_SPACE) begin
            consume = 1'b1;
            proceed = 1'b0;
          end else if (sub_q) begin
            skip_n = 1'b0;
          end else if (fill_q < WIN_IDX_W'(SELECT_LEN) && !last_seen_q) begin
            proceed = 1'b0;
          end else begin
            skip_n = 1'b0;
            if (sel_hit) begin
              sub_n   = 1'b1;
              level_n = depth_q;
              consume = 1'b1;
              proceed = 1'b0;
            end
          end
        end
        if (proceed) begin
          case (head.kind)
            KIND_BSLASH: begin
              esc_n   = 1'b1;
              consume = 1'b1;
            end
            KIND_QUOTE: begin
              quote_n = !quote_q;
              consume = 1'b1;
            end
            KIND_OPEN: begin
              if (!quote_q) begin
                depth_n = depth_q + 1'b1;
                skip_n  = 1'b1;
              end
              consume = 1'b1;
            end
            KIND_CLOSE: begin
              if (!quote_q) begin
                if (sub_q && depth_q == level_q) begin
                  sub_n = 1'b0;
                end
                depth_n = depth_q - 1'b1;
              end
              consume = 1'b1;
            end
            default: begin
              if (quote_q || sub_q) begin
                consume = 1'b1;
              end else if (fill_q >= len_eff || last_seen_q) begin
                if (pat_hit) begin
                  hit = 1'b1;
                end else begin
                  consume = 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  assign not_found = (fill_q == '0) && last_seen_q && !discard_q;
  assign emit      = hit || not_found;
  assign stall     = emit && res_full_i;
  assign room      = (fill_q != WIN_IDX_W'(WIN_DEPTH)) || consume;
  assign append    = in_valid_i && !discard_q && !last_seen_q && !hit && room && !stall;
  assign drop      = in_valid_i && discard_q;
  assign in_pop_o  = append || drop;
  assign wr_idx    = fill_q - WIN_IDX_W'(consume);

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    last_seen_d = last_seen_q;
    esc_d       = esc_q;
    skip_d      = skip_q;
    quote_d     = quote_q;
    sub_d       = sub_q;
    depth_d     = depth_q;
    level_d     = level_q;
    byte_cnt_d  = byte_cnt_q;
    scan_idx_d  = scan_idx_q;
    discard_d   = discard_q;
    if (!stall) begin
      esc_d   = esc_n;
      skip_d  = skip_n;
      quote_d = quote_n;
      sub_d   = sub_n;
      depth_d = depth_n;
      level_d = level_n;
      if (consume) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        if (scan_idx_q != CNT_MAX) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      if (append) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (wr_idx == WIN_IDX_W'(i)) begin
            win_d[i] = in_item_i.ch;
          end
        end
        if (byte_cnt_q != CNT_MAX) begin
          byte_cnt_d = byte_cnt_q + 1'b1;
        end
        last_seen_d = in_item_i.last;
      end
      fill_d = fill_q - WIN_IDX_W'(consume) + WIN_IDX_W'(append);
      // text finished or hit: scan state starts over
      if (emit) begin
        fill_d      = '0;
        last_seen_d = 1'b0;
        esc_d       = 1'b0;
        skip_d      = 1'b0;
        quote_d     = 1'b0;
        sub_d       = 1'b0;
        depth_d     = '0;
        level_d     = '0;
        byte_cnt_d  = '0;
        scan_idx_d  = '0;
        discard_d   = hit && !last_seen_q;
      end
      if (drop && in_item_i.last) begin
        discard_d = 1'b0;
      end
    end
  end

  always_comb begin
    pos_sum = SUM_W'(cfg_i.start_offset) + SUM_W'(hit ? scan_idx_q : byte_cnt_q);
    pos_sat = (pos_sum > SAT_LIM) ? SAT_LIM : pos_sum;
  end

  assign res_push_o     = emit && !stall;
  assign res_o.found    = hit;
  assign res_o.position = POS_W'(pos_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      last_seen_q <= 1'b0;
      esc_q       <= 1'b0;
      skip_q      <= 1'b0;
      quote_q     <= 1'b0;
      sub_q       <= 1'b0;
      depth_q     <= '0;
      level_q     <= '0;
      byte_cnt_q  <= '0;
      scan_idx_q  <= '0;
      discard_q   <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      last_seen_q <= last_seen_d;
      esc_q       <= esc_d;
      skip_q      <= skip_d;
      quote_q     <= quote_d;
      sub_q       <= sub_d;
      depth_q     <= depth_d;
      level_q     <= level_d;
      byte_cnt_q  <= byte_cnt_d;
      scan_idx_q  <= scan_idx_d;
      discard_q   <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // after a hit the window stays empty until the text ends
  a_discard_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> fill_q == '0)
    else $error("window holds bytes while discarding");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_not_found_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !res_o.found |=> fill_q == '0 && !last_seen_q && byte_cnt_q == '0)
    else $error("scan state not cleared after end of text");

  a_hit_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.found && !last_seen_q |=> discard_q)
    else $error("hit mid-text did not enter discard");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_idx_q <= byte_cnt_q)
    else $error("scan index ahead of byte count");

endmodule

/* rtl/quote_aware_substring_finder.sv */
// ----------------------------------------------------------------------------
// quote_aware_substring_finder
// Streams SQL text and reports the first case-folded pattern match outside
// quotes and select subqueries, or not-found with the text length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: text bytes are pushed with push/full; last_byte_i marks
//   the final byte of a text. Result channel: empty/pop; one result per
//   text, found_o with the match position, or found_o low with the text
//   length. Positions include start_offset and saturate.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i;
//   write only while no text is in flight.
// Throughput: one byte per cycle within a text, set by the scanner deciding
//   one window position per cycle while no result waits on a full result
//   queue. After a text's last byte the window drains one position a cycle
//   (up to the larger of the pattern length and six), and any not-found result
//   is given, before the next text's bytes enter the window; meanwhile the
//   input queue takes IN_DEPTH beats, then full rises. Bytes pass the input queue
//   and the window; results are registered in the result queue.
// Reset clears all scan state and queues; registers return to length 1,
//   zero pattern and zero offset. When the receiver stalls, results wait in
//   the result queue and the scanner holds only when it has another to give.
// ----------------------------------------------------------------------------
module quote_aware_substring_finder
  import qasf_pkg::*;
#(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 16,
  parameter int IN_DEPTH      = 4,
  parameter int OUT_DEPTH     = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            text_byte_i,
  input  logic                  last_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  found_o,
  output logic [POS_W-1:0]      position_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_pop;
  logic  res_full, res_push;
  res_t  res_in, res_out;
  logic [$bits(res_t)-1:0] res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= 5'd1;
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.start_offset   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data_i[4:0];
        CFG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_data_i;
        CFG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_data_i;
        CFG_START_OFFSET:   cfg_q.start_offset   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  qasf_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .text_byte_i(text_byte_i),
    .last_byte_i(last_byte_i),
    .valid_o    (item_valid),
    .item_o     (item),
    .pop_i      (item_pop)
  );

  qasf_back #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(item_valid),
    .in_item_i (item),
    .in_pop_o  (item_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_in)
  );

  qasf_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_data),
    .empty_o(empty)
  );

  assign res_out    = res_t'(res_data);
  assign found_o    = res_out.found;
  assign position_o = res_out.position;

endmodule
